>>> src/kmst_pkg.sv
`timescale 1ns / 1ps
// Package for the minimum spanning tree core: widths, sizes and the
// command and status structs between controller and datapath. No dependencies.
package kmst_pkg;

  localparam int NODES     = 32;
  localparam int NODE_W    = 5;
  localparam int COST_W    = 16;
  localparam int MAX_EDGES = 256;
  localparam int ADDR_W    = $clog2(MAX_EDGES);
  localparam int CNT_W     = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W    = 2 * NODE_W + COST_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the edge of an input transfer
    logic clr_init;   // start of a run: reset pointer and scan history
    logic clr_step;   // write one parent entry with its own index
    logic scan_init;  // restart the minimum search
    logic scan_step;  // issue one edge store read
    logic pick;       // take the found minimum as the current edge
    logic find_next;  // follow one parent link
    logic root_a;     // first root found, start on the second end
    logic merge;      // link the two roots and add the cost
    logic push;       // move the pending result out, hold the new one
    logic finish;     // emit the final result and end the run
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;   // every stored edge has been read in this pass
    logic clr_done;   // the last parent entry is being written
    logic best_vld;   // the pass found a next edge
    logic root_hit;   // the parent read back equals the cursor
    logic same_root;  // second root equals the first root
    logic pend_vld;   // a result waits in the pending register
    logic out_free;   // the output register can take a result
  } sts_t;

endpackage

>>> src/kmst_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/kmst_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the spanning tree core.
// Depends on kmst_pkg for the command and status structs.
module kmst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           final_edge,
  output logic           in_ready,
  input  kmst_pkg::sts_t sts,
  output kmst_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_PICK  = 4'd3;
  localparam logic [3:0] S_FA_RD = 4'd4;
  localparam logic [3:0] S_FA_CK = 4'd5;
  localparam logic [3:0] S_FB_RD = 4'd6;
  localparam logic [3:0] S_FB_CK = 4'd7;
  localparam logic [3:0] S_MERGE = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_FINAL = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (final_edge) begin
            cmd.clr_init = 1'b1;
            state_next   = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_next = S_PICK;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_PICK: begin
        if (sts.best_vld) begin
          cmd.pick   = 1'b1;
          state_next = S_FA_RD;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FA_RD: state_next = S_FA_CK;
      S_FA_CK: begin
        if (sts.root_hit) begin
          cmd.root_a = 1'b1;
          state_next = S_FB_RD;
        end else begin
          cmd.find_next = 1'b1;
          state_next    = S_FA_RD;
        end
      end
      S_FB_RD: state_next = S_FB_CK;
      S_FB_CK: begin
        if (sts.root_hit) begin
          if (sts.same_root) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end else begin
            state_next = S_MERGE;
          end
        end else begin
          cmd.find_next = 1'b1;
          state_next    = S_FB_RD;
        end
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (sts.out_free || !sts.pend_vld) begin
          cmd.push      = 1'b1;
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/kmst_dp.sv
`timescale 1ns / 1ps
// Datapath of the spanning tree core: edge store, parent store, minimum
// search, root walk, pending and output registers. Depends on kmst_pkg, kmst_ram.
module kmst_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  kmst_pkg::cmd_t               cmd,
  output kmst_pkg::sts_t               sts,
  input  logic [kmst_pkg::NODE_W-1:0]  first_node,
  input  logic [kmst_pkg::NODE_W-1:0]  second_node,
  input  logic [kmst_pkg::COST_W-1:0]  edge_cost,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [kmst_pkg::NODE_W-1:0]  tree_first_node,
  output logic [kmst_pkg::NODE_W-1:0]  tree_second_node,
  output logic [kmst_pkg::COST_W-1:0]  tree_edge_cost,
  output logic [kmst_pkg::COST_W-1:0]  running_total,
  output logic                         has_edge,
  output logic                         overflowed,
  output logic                         last_result
);

  logic [kmst_pkg::CNT_W-1:0]  count;
  logic                        ovf;
  logic [kmst_pkg::COST_W-1:0] sum;
  logic [kmst_pkg::CNT_W-1:0]  ptr;

  logic                         scan_vld;
  logic [kmst_pkg::ADDR_W-1:0]  scan_idx;
  logic                         have_prev;
  logic [kmst_pkg::COST_W-1:0]  prev_cost;
  logic [kmst_pkg::ADDR_W-1:0]  prev_idx;
  logic                         best_vld;
  logic [kmst_pkg::COST_W-1:0]  best_cost;
  logic [kmst_pkg::ADDR_W-1:0]  best_idx;
  logic [kmst_pkg::NODE_W-1:0]  best_a;
  logic [kmst_pkg::NODE_W-1:0]  best_b;

  logic [kmst_pkg::NODE_W-1:0]  x;
  logic [kmst_pkg::NODE_W-1:0]  ra;

  logic                         pend_vld;
  logic [kmst_pkg::NODE_W-1:0]  pend_a;
  logic [kmst_pkg::NODE_W-1:0]  pend_b;
  logic [kmst_pkg::COST_W-1:0]  pend_cost;
  logic [kmst_pkg::COST_W-1:0]  pend_total;

  logic                         e_we;
  logic [kmst_pkg::EDGE_W-1:0]  e_rdata;
  logic [kmst_pkg::NODE_W-1:0]  d_a;
  logic [kmst_pkg::NODE_W-1:0]  d_b;
  logic [kmst_pkg::COST_W-1:0]  d_cost;
  logic                         after_prev;
  logic                         below_best;

  logic                         p_we;
  logic [kmst_pkg::NODE_W-1:0]  p_waddr;
  logic [kmst_pkg::NODE_W-1:0]  p_wdata;
  logic [kmst_pkg::NODE_W-1:0]  p_rdata;
  logic                         out_free;

  // Edge store: written in arrival order, read by the minimum search.
  assign e_we = cmd.load && (count < kmst_pkg::CNT_W'(kmst_pkg::MAX_EDGES));

  kmst_ram #(
    .WIDTH(kmst_pkg::EDGE_W),
    .DEPTH(kmst_pkg::MAX_EDGES)
  ) u_edge_ram (
    .clk  (clk),
    .we   (e_we),
    .waddr(count[kmst_pkg::ADDR_W-1:0]),
    .wdata({first_node, second_node, edge_cost}),
    .raddr(ptr[kmst_pkg::ADDR_W-1:0]),
    .rdata(e_rdata)
  );

  assign {d_a, d_b, d_cost} = e_rdata;

  // Parent store: cleared at run start, linked on merge, read at the cursor.
  assign p_we    = cmd.clr_step || cmd.merge;
  assign p_waddr = cmd.clr_step ? ptr[kmst_pkg::NODE_W-1:0] : ra;
  assign p_wdata = cmd.clr_step ? ptr[kmst_pkg::NODE_W-1:0] : x;

  kmst_ram #(
    .WIDTH(kmst_pkg::NODE_W),
    .DEPTH(kmst_pkg::NODES)
  ) u_parent_ram (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(x),
    .rdata(p_rdata)
  );

  // Ordering of the read edge against the last taken edge and the best so far.
  // Equal costs are ordered by store index, which keeps arrival order.
  assign after_prev = !have_prev || (d_cost > prev_cost)
                      || ((d_cost == prev_cost) && (scan_idx > prev_idx));
  assign below_best = !best_vld || (d_cost < best_cost);

  assign out_free = !out_valid || out_ready;

  assign sts.scan_end  = (ptr >= count);
  assign sts.clr_done  = (ptr[kmst_pkg::NODE_W-1:0] == kmst_pkg::NODE_W'(kmst_pkg::NODES - 1));
  assign sts.best_vld  = best_vld;
  assign sts.root_hit  = (p_rdata == x);
  assign sts.same_root = (x == ra);
  assign sts.pend_vld  = pend_vld;
  assign sts.out_free  = out_free;

  // Edge count, overflow flag and running total.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      sum   <= '0;
    end else if (cmd.finish) begin
      count <= '0;
      ovf   <= 1'b0;
      sum   <= '0;
    end else begin
      if (cmd.load) begin
        if (e_we) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.merge) begin
        sum <= sum + best_cost;
      end
    end
  end

  // Shared pointer, scan pipeline and search history.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      scan_vld  <= 1'b0;
      have_prev <= 1'b0;
      best_vld  <= 1'b0;
    end else begin
      if (cmd.clr_init || cmd.scan_init) begin
        ptr <= '0;
      end else if (cmd.clr_step || cmd.scan_step) begin
        ptr <= ptr + 1'b1;
      end
      scan_vld <= cmd.scan_step;
      if (cmd.clr_init) begin
        have_prev <= 1'b0;
      end else if (cmd.pick) begin
        have_prev <= 1'b1;
      end
      if (cmd.scan_init) begin
        best_vld <= 1'b0;
      end else if (scan_vld && after_prev && below_best) begin
        best_vld <= 1'b1;
      end
    end
  end

  // Search payload and root walk cursor.
  always_ff @(posedge clk) begin
    scan_idx <= ptr[kmst_pkg::ADDR_W-1:0];
    if (scan_vld && after_prev && below_best) begin
      best_cost <= d_cost;
      best_idx  <= scan_idx;
      best_a    <= d_a;
      best_b    <= d_b;
    end
    if (cmd.pick) begin
      prev_cost <= best_cost;
      prev_idx  <= best_idx;
      x         <= best_a;
    end else if (cmd.root_a) begin
      ra <= x;
      x  <= best_b;
    end else if (cmd.find_next) begin
      x <= p_rdata;
    end
  end

  // Pending result: held until it is known whether another edge follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (cmd.finish) begin
      pend_vld <= 1'b0;
    end else if (cmd.push) begin
      pend_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend_a     <= best_a;
      pend_b     <= best_b;
      pend_cost  <= best_cost;
      pend_total <= sum;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.push && pend_vld) || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.push && pend_vld) || cmd.finish) begin
      tree_first_node  <= pend_vld ? pend_a : '0;
      tree_second_node <= pend_vld ? pend_b : '0;
      tree_edge_cost   <= pend_vld ? pend_cost : '0;
      running_total    <= pend_vld ? pend_total : '0;
      has_edge         <= pend_vld;
      overflowed       <= ovf;
      last_result      <= cmd.finish;
    end
  end

endmodule

>>> src/kruskal_min_spanning_tree_core.sv
`timescale 1ns / 1ps
// Minimum spanning tree core. Edges load one per cycle; input then stays closed until the
// final result enters the output register. After the last edge the parent store is cleared,
// then one search pass runs per stored edge plus one closing pass that finds none. Each
// found edge gets a root walk from both of its ends, and each tree edge is linked and then
// emitted (the emit waits while the output stalls). Synchronous active-high reset empties the
// edge list and the output register. Depends on kmst_pkg, kmst_ctrl, kmst_dp.
module kruskal_min_spanning_tree_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kmst_pkg::NODE_W-1:0] first_node,
  input  logic [kmst_pkg::NODE_W-1:0] second_node,
  input  logic [kmst_pkg::COST_W-1:0] edge_cost,
  input  logic                        final_edge,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kmst_pkg::NODE_W-1:0] tree_first_node,
  output logic [kmst_pkg::NODE_W-1:0] tree_second_node,
  output logic [kmst_pkg::COST_W-1:0] tree_edge_cost,
  output logic [kmst_pkg::COST_W-1:0] running_total,
  output logic                        has_edge,
  output logic                        overflowed,
  output logic                        last_result
);

  kmst_pkg::cmd_t cmd;
  kmst_pkg::sts_t sts;

  // Sequencer.
  kmst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .final_edge(final_edge),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  kmst_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .first_node      (first_node),
    .second_node     (second_node),
    .edge_cost       (edge_cost),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .tree_first_node (tree_first_node),
    .tree_second_node(tree_second_node),
    .tree_edge_cost  (tree_edge_cost),
    .running_total   (running_total),
    .has_edge        (has_edge),
    .overflowed      (overflowed),
    .last_result     (last_result)
  );

endmodule

>>> src/kmst_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the spanning tree core, bound to the top level.
// Depends on kruskal_min_spanning_tree_core.
module kmst_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        final_edge,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] tree_edge_cost,
  input logic [15:0] running_total,
  input logic        has_edge,
  input logic        last_result
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(running_total))
    else $error("stalled result changed");

  // An empty tree result is always the last of its run.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_edge |-> last_result)
    else $error("empty result not marked last");

  // An empty tree result carries zero cost and total.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_edge |-> (tree_edge_cost == 16'd0) && (running_total == 16'd0))
    else $error("empty result carries data");

  // The final edge transfer starts a run, so input closes.
  a_run_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && final_edge |=> !in_ready)
    else $error("input open after final edge");

endmodule

bind kruskal_min_spanning_tree_core kmst_checker u_kmst_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .final_edge    (final_edge),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .tree_edge_cost(tree_edge_cost),
  .running_total (running_total),
  .has_edge      (has_edge),
  .last_result   (last_result)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for kruskal_min_spanning_tree_core: edge lists go in
// over valid/ready, and every tree result is checked against a local predictor.
// Depends on kmst_pkg and the core RTL.
module tb_top;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [kmst_pkg::NODE_W-1:0] a;
    logic [kmst_pkg::NODE_W-1:0] b;
    logic [kmst_pkg::COST_W-1:0] cost;
    logic                        fin;
  } edge_item_t;

  typedef struct packed {
    logic [kmst_pkg::NODE_W-1:0] a;
    logic [kmst_pkg::NODE_W-1:0] b;
    logic [kmst_pkg::COST_W-1:0] cost;
    logic [kmst_pkg::COST_W-1:0] total;
    logic                        has;
    logic                        ovf;
    logic                        last;
  } tree_result_t;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [kmst_pkg::NODE_W-1:0] first_node, second_node;
  logic [kmst_pkg::COST_W-1:0] edge_cost;
  logic final_edge;
  logic out_valid, out_ready;
  logic [kmst_pkg::NODE_W-1:0] tree_first_node, tree_second_node;
  logic [kmst_pkg::COST_W-1:0] tree_edge_cost, running_total;
  logic has_edge, overflowed, last_result;

  edge_item_t   edge_q[$];
  tree_result_t tree_q[$];
  int           failures = 0;
  int           cycles = 0;
  int           gap_left = 0;
  int           burst_left = 0;
  int           stall_mode = 0;

  // Predictor copy of the edge list.
  logic [kmst_pkg::NODE_W-1:0] list_a[kmst_pkg::MAX_EDGES];
  logic [kmst_pkg::NODE_W-1:0] list_b[kmst_pkg::MAX_EDGES];
  logic [kmst_pkg::COST_W-1:0] list_cost[kmst_pkg::MAX_EDGES];
  int                          list_count = 0;
  bit                          list_ovf = 0;

  kruskal_min_spanning_tree_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_node(first_node), .second_node(second_node),
    .edge_cost(edge_cost), .final_edge(final_edge),
    .out_valid(out_valid), .out_ready(out_ready),
    .tree_first_node(tree_first_node), .tree_second_node(tree_second_node),
    .tree_edge_cost(tree_edge_cost), .running_total(running_total),
    .has_edge(has_edge), .overflowed(overflowed), .last_result(last_result)
  );

  // Append one pending input item.
  function automatic void queue_edge(edge_item_t e);
    edge_q.insert(edge_q.size(), e);
  endfunction

  // Append one expected result.
  function automatic void queue_result(tree_result_t r);
    tree_q.insert(tree_q.size(), r);
  endfunction

  // Store one accepted edge; on the final edge, build the spanning tree.
  function automatic void build_tree(edge_item_t e);
    int order[kmst_pkg::MAX_EDGES];
    logic [kmst_pkg::NODE_W-1:0] parent[kmst_pkg::NODES];
    logic [kmst_pkg::COST_W-1:0] sum;
    int j, ra, rb, taken;
    tree_result_t r;
    if (list_count < kmst_pkg::MAX_EDGES) begin
      list_a[list_count] = e.a;
      list_b[list_count] = e.b;
      list_cost[list_count] = e.cost;
      list_count++;
    end else begin
      list_ovf = 1;
    end
    if (!e.fin) return;
    // Stable insertion sort of edge indices by cost.
    for (int i = 0; i < list_count; i++) begin
      j = i;
      while (j > 0 && list_cost[order[j-1]] > list_cost[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < kmst_pkg::NODES; i++) parent[i] = kmst_pkg::NODE_W'(i);
    sum = '0;
    taken = 0;
    for (int i = 0; i < list_count; i++) begin
      ra = list_a[order[i]];
      rb = list_b[order[i]];
      while (parent[ra] != ra) ra = parent[ra];
      while (parent[rb] != rb) rb = parent[rb];
      if (ra == rb) continue;
      parent[ra] = kmst_pkg::NODE_W'(rb);
      sum = sum + list_cost[order[i]];
      if (taken < 31) begin
        r = '{a: list_a[order[i]], b: list_b[order[i]], cost: list_cost[order[i]],
              total: sum, has: 1'b1, ovf: list_ovf, last: 1'b0};
        queue_result(r);
        taken++;
      end
    end
    if (taken == 0) begin
      r = '{a: '0, b: '0, cost: '0, total: '0, has: 1'b0, ovf: list_ovf, last: 1'b1};
      queue_result(r);
    end else begin
      tree_q[tree_q.size()-1].last = 1'b1;
    end
    list_count = 0;
    list_ovf = 0;
  endfunction

  task automatic check_field(string name, int expd, int actual);
    if (expd != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expd, actual);
      failures++;
    end
  endtask

  // Queue one edge list with nodes up to node_span and costs up to cost_max.
  task automatic add_run(int n, int node_span, int cost_max);
    edge_item_t e;
    for (int i = 0; i < n; i++) begin
      e.a = kmst_pkg::NODE_W'($urandom_range(0, node_span));
      e.b = kmst_pkg::NODE_W'($urandom_range(0, node_span));
      e.cost = kmst_pkg::COST_W'($urandom_range(0, cost_max));
      e.fin = (i == n - 1);
      queue_edge(e);
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      first_node <= '0;
      second_node <= '0;
      edge_cost <= '0;
      final_edge <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) build_tree('{a: first_node, b: second_node, cost: edge_cost,
                                 fin: final_edge});
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (edge_q.size() > 0) begin
        edge_item_t e;
        e = edge_q.pop_front();
        first_node <= e.a;
        second_node <= e.b;
        edge_cost <= e.cost;
        final_edge <= e.fin;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expected result.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tree_q.size() == 0) begin
          $error("unexpected result transfer");
          failures++;
        end else begin
          tree_result_t r;
          r = tree_q.pop_front();
          check_field("tree_first_node", r.a, tree_first_node);
          check_field("tree_second_node", r.b, tree_second_node);
          check_field("tree_edge_cost", r.cost, tree_edge_cost);
          check_field("running_total", r.total, running_total);
          check_field("has_edge", r.has, has_edge);
          check_field("overflowed", r.ovf, overflowed);
          check_field("last_result", r.last, last_result);
        end
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    edge_item_t e;
    int total_items;
    rst = 1'b1;
    // Directed: a lone self loop gives the empty tree.
    queue_edge('{a: 5'd3, b: 5'd3, cost: 16'd100, fin: 1'b1});
    // A single edge between the extreme nodes at the top cost.
    queue_edge('{a: 5'd0, b: 5'd31, cost: 16'hFFFF, fin: 1'b1});
    // Total wraps past 65535; a zero-cost self loop is skipped.
    queue_edge('{a: 5'd31, b: 5'd0, cost: 16'hFFFF, fin: 1'b0});
    queue_edge('{a: 5'd1, b: 5'd2, cost: 16'd1, fin: 1'b0});
    queue_edge('{a: 5'd5, b: 5'd5, cost: 16'd0, fin: 1'b1});
    // Equal costs keep arrival order; the closing edge of a cycle is refused.
    queue_edge('{a: 5'd1, b: 5'd2, cost: 16'd7, fin: 1'b0});
    queue_edge('{a: 5'd2, b: 5'd3, cost: 16'd7, fin: 1'b0});
    queue_edge('{a: 5'd1, b: 5'd3, cost: 16'd7, fin: 1'b1});
    // A chain over all nodes gives the most results per run.
    for (int i = 0; i < 31; i++) begin
      e = '{a: kmst_pkg::NODE_W'(i), b: kmst_pkg::NODE_W'(i + 1),
            cost: kmst_pkg::COST_W'(31 - i), fin: (i == 30)};
      queue_edge(e);
    end
    total_items = 39;
    while (total_items < 200) begin
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      case ($urandom_range(0, 2))
        0: add_run(n, 31, 65535);
        1: add_run(n, 7, 15);
        default: add_run(n, $urandom_range(1, 31), $urandom_range(0, 65535));
      endcase
      total_items += n;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (edge_q.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (tree_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/kmst_pkg.sv
src/kmst_ram.sv
src/kmst_ctrl.sv
src/kmst_dp.sv
src/kruskal_min_spanning_tree_core.sv
src/kmst_checker.sv
tb/sv/tb_top.sv
